// ===== hw/rtl/dlbd_pkg.sv =====
// Shared types, widths and constants for the definite-length block deframer.
package dlbd_pkg;

   localparam int BYTE_W       = 8;
   localparam int KIND_W       = 2;
   localparam int CHAN_W       = 2;
   localparam int OFFSET_W     = 22;
   localparam int LENGTH_W     = 30;
   localparam int EVENT_W      = 32;
   localparam int POINTS_W     = 21;
   localparam int MASK_W       = 4;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 21;
   localparam int DCOUNT_W     = 4;
   localparam int CHCOUNT_W    = 3;

   localparam logic [POINTS_W-1:0] MAX_POINTS        = POINTS_W'(1048576);
   localparam logic [DCOUNT_W-1:0] MAX_LENGTH_DIGITS = DCOUNT_W'(9);
   localparam logic [DCOUNT_W-1:0] COUNT_PENDING     = DCOUNT_W'(15);

   localparam logic [POINTS_W-1:0] POINTS_RESET = POINTS_W'(1024);
   localparam logic [MASK_W-1:0]   MASK_RESET   = MASK_W'(1);

   localparam logic [BYTE_W-1:0] CHAR_HASH    = 8'h23;
   localparam logic [BYTE_W-1:0] CHAR_SEMI    = 8'h3B;
   localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

   localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EVENT  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_POINTS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASK   = 1'd1;

   typedef enum logic [1:0] {
      PH_AWAIT,
      PH_HEADER,
      PH_SAMPLES,
      PH_TRAILER
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0]   result_kind;
      logic [BYTE_W-1:0]   sample_value;
      logic [CHAN_W-1:0]   channel_number;
      logic [OFFSET_W-1:0] event_offset;
      logic [LENGTH_W-1:0] declared_length;
      logic [EVENT_W-1:0]  event_number;
   } rsp_beat_type;

endpackage

// ===== hw/rtl/dlbd_if.sv =====
// Valid/ready channel interfaces for stream bytes, results and register writes.
interface dlbd_req_if import dlbd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink (input valid, input stream_byte, output ready);
endinterface

interface dlbd_rsp_if import dlbd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   result_kind;
   logic [BYTE_W-1:0]   sample_value;
   logic [CHAN_W-1:0]   channel_number;
   logic [OFFSET_W-1:0] event_offset;
   logic [LENGTH_W-1:0] declared_length;
   logic [EVENT_W-1:0]  event_number;

   modport source (output valid, output result_kind, output sample_value,
                   output channel_number, output event_offset,
                   output declared_length, output event_number, input ready);
   modport sink (input valid, input result_kind, input sample_value,
                 input channel_number, input event_offset,
                 input declared_length, input event_number, output ready);
endinterface

interface dlbd_csr_if import dlbd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/definite_length_block_deframer.sv =====
// Top level of the definite-length block deframer.
//
// req_chan carries one stream byte per beat. Each channel block opens with
// '#', a digit-count byte and that many decimal length digits; a header beat
// reports the parsed length, then points_per_channel sample beats follow,
// tagged with channel and event offset. After the last enabled channel,
// bytes are dropped until a newline, which yields an event-complete beat.
// csr_chan writes register 0 (points_per_channel) or 1 (channel_mask); it is
// always ready and a write takes effect on the next byte.
// Throughput is one byte per cycle unless rsp_chan stalls. A result appears
// on rsp_chan the cycle after its byte, from a single output register.
// While rsp_chan stalls, that register holds its beat and req_chan.ready
// drops; it rises again in the cycle the beat is taken.
// Synchronous reset returns to the awaiting-header phase, clears all
// counters and loads points_per_channel 1024 and channel_mask 1.
module definite_length_block_deframer import dlbd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   dlbd_req_if.sink    req_chan,
   dlbd_rsp_if.source  rsp_chan,
   dlbd_csr_if.sink    csr_chan
);

   logic [POINTS_W-1:0]  points_ff;
   logic [MASK_W-1:0]    mask_ff;

   phase_type            phase_ff, phase_in;
   logic [DCOUNT_W-1:0]  digit_count_ff, digit_count_in;
   logic [DCOUNT_W-1:0]  seen_ff, seen_in;
   logic [LENGTH_W-1:0]  acc_ff, acc_in;
   logic                 stopped_ff, stopped_in;
   logic [CHCOUNT_W-1:0] chan_ff, chan_in;
   logic [POINTS_W-1:0]  sample_ff, sample_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;
   logic [EVENT_W-1:0]   event_ff, event_in;

   logic                 out_valid_ff, out_valid_in;
   rsp_beat_type         out_beat_ff;
   rsp_beat_type         beat;
   logic                 emit;

   logic                 accept;
   logic [BYTE_W-1:0]    in_byte;
   logic                 is_digit, is_hash, is_newline;
   logic [DCOUNT_W-1:0]  digit;
   logic                 pending;
   logic [DCOUNT_W-1:0]  count_sel;
   logic                 take_digit;
   logic [LENGTH_W-1:0]  acc_step;
   logic [DCOUNT_W-1:0]  seen_step;
   logic                 digits_done;
   logic [POINTS_W-1:0]  eff_points;
   logic [CHCOUNT_W-1:0] eff_chans, mask_pop;
   logic [POINTS_W-1:0]  sample_step;
   logic                 block_end;
   logic [CHCOUNT_W-1:0] chan_step;
   logic                 event_full;

   assign req_chan.ready = !out_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign in_byte        = req_chan.stream_byte;

   assign is_digit   = in_byte inside {[CHAR_ZERO:CHAR_NINE]};
   assign is_hash    = in_byte == CHAR_HASH;
   assign is_newline = in_byte == CHAR_NEWLINE;
   assign digit      = in_byte[DCOUNT_W-1:0];
   assign pending    = digit_count_ff == COUNT_PENDING;
   assign count_sel  = !is_digit ? '0 :
                       (digit > MAX_LENGTH_DIGITS) ? MAX_LENGTH_DIGITS : digit;
   assign take_digit = is_digit && !stopped_ff;
   assign acc_step   = take_digit ?
                       (acc_ff << 3) + (acc_ff << 1) + LENGTH_W'(digit) : acc_ff;
   assign seen_step   = seen_ff + DCOUNT_W'(1);
   assign digits_done = seen_step >= digit_count_ff;

   assign eff_points = (points_ff == '0) ? POINTS_W'(1) :
                       (points_ff > MAX_POINTS) ? MAX_POINTS : points_ff;
   assign mask_pop   = CHCOUNT_W'(mask_ff[0]) + CHCOUNT_W'(mask_ff[1]) +
                       CHCOUNT_W'(mask_ff[2]) + CHCOUNT_W'(mask_ff[3]);
   assign eff_chans  = (mask_pop == '0) ? CHCOUNT_W'(1) : mask_pop;
   assign sample_step = sample_ff + POINTS_W'(1);
   assign block_end   = sample_step >= eff_points;
   assign chan_step   = chan_ff + CHCOUNT_W'(1);
   assign event_full  = chan_step >= eff_chans;

   // next state
   always_comb begin
      phase_in       = phase_ff;
      digit_count_in = digit_count_ff;
      seen_in        = seen_ff;
      acc_in         = acc_ff;
      stopped_in     = stopped_ff;
      chan_in        = chan_ff;
      sample_in      = sample_ff;
      offset_in      = offset_ff;
      event_in       = event_ff;
      if (accept) begin
         case (phase_ff)
            PH_AWAIT, PH_HEADER: begin
               if (is_hash) begin
                  phase_in       = PH_HEADER;
                  digit_count_in = COUNT_PENDING;
                  seen_in        = '0;
                  acc_in         = '0;
                  stopped_in     = 1'b0;
               end else if (phase_ff == PH_HEADER) begin
                  if (pending) begin
                     digit_count_in = count_sel;
                     seen_in        = '0;
                     if (count_sel == '0) begin
                        phase_in  = PH_SAMPLES;
                        sample_in = '0;
                     end
                  end else begin
                     acc_in     = acc_step;
                     stopped_in = stopped_ff || !take_digit;
                     seen_in    = seen_step;
                     if (digits_done) begin
                        phase_in  = PH_SAMPLES;
                        sample_in = '0;
                     end
                  end
               end
            end
            PH_SAMPLES: begin
               offset_in = offset_ff + OFFSET_W'(1);
               if (block_end) begin
                  sample_in = '0;
                  chan_in   = chan_step;
                  phase_in  = event_full ? PH_TRAILER : PH_AWAIT;
               end else begin
                  sample_in = sample_step;
               end
            end
            PH_TRAILER: begin
               if (is_newline) begin
                  event_in  = event_ff + EVENT_W'(1);
                  chan_in   = '0;
                  offset_in = '0;
                  sample_in = '0;
                  phase_in  = PH_AWAIT;
               end
            end
            default: phase_in = PH_AWAIT;
         endcase
      end
   end

   // outputs
   always_comb begin
      emit                 = 1'b0;
      beat.result_kind     = KIND_SAMPLE;
      beat.sample_value    = '0;
      beat.channel_number  = '0;
      beat.event_offset    = '0;
      beat.declared_length = '0;
      beat.event_number    = event_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (!is_hash && (pending ? (count_sel == '0) : digits_done)) begin
               emit                 = 1'b1;
               beat.result_kind     = KIND_HEADER;
               beat.channel_number  = chan_ff[CHAN_W-1:0];
               beat.event_offset    = offset_ff;
               beat.declared_length = pending ? acc_ff : acc_step;
            end
         end
         PH_SAMPLES: begin
            emit                = 1'b1;
            beat.result_kind    = KIND_SAMPLE;
            beat.sample_value   = in_byte;
            beat.channel_number = chan_ff[CHAN_W-1:0];
            beat.event_offset   = offset_ff;
         end
         PH_TRAILER: begin
            if (is_newline) begin
               emit             = 1'b1;
               beat.result_kind = KIND_EVENT;
            end
         end
         default: emit = 1'b0;
      endcase
   end

   assign out_valid_in = accept ? emit : (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff      <= POINTS_RESET;
         mask_ff        <= MASK_RESET;
         phase_ff       <= PH_AWAIT;
         digit_count_ff <= '0;
         seen_ff        <= '0;
         acc_ff         <= '0;
         stopped_ff     <= 1'b0;
         chan_ff        <= '0;
         sample_ff      <= '0;
         offset_ff      <= '0;
         event_ff       <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         seen_ff        <= seen_in;
         acc_ff         <= acc_in;
         stopped_ff     <= stopped_in;
         chan_ff        <= chan_in;
         sample_ff      <= sample_in;
         offset_ff      <= offset_in;
         event_ff       <= event_in;
         out_valid_ff   <= out_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_POINTS: points_ff <= csr_chan.data[POINTS_W-1:0];
               CSR_MASK:   mask_ff   <= csr_chan.data[MASK_W-1:0];
               default:    points_ff <= points_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_beat_ff <= beat;
      end
   end

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.result_kind     = out_beat_ff.result_kind;
   assign rsp_chan.sample_value    = out_beat_ff.sample_value;
   assign rsp_chan.channel_number  = out_beat_ff.channel_number;
   assign rsp_chan.event_offset    = out_beat_ff.event_offset;
   assign rsp_chan.declared_length = out_beat_ff.declared_length;
   assign rsp_chan.event_number    = out_beat_ff.event_number;

`ifndef SYNTHESIS
   a_await_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_AWAIT) |=> !rsp_chan.valid)
      else $error("byte outside a block produced a beat");

   a_event_close: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_TRAILER && is_newline) |=>
      (rsp_chan.valid && rsp_chan.result_kind == KIND_EVENT &&
       phase_ff == PH_AWAIT && offset_ff == '0 && chan_ff == '0))
      else $error("newline in trailer did not close the event");

   a_sample_beat: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_SAMPLES) |=>
      (rsp_chan.valid && rsp_chan.result_kind == KIND_SAMPLE &&
       rsp_chan.sample_value == $past(in_byte)))
      else $error("sample byte not passed through");

   a_chan_bound: assert property (@(posedge clock) disable iff (reset)
      chan_ff <= CHCOUNT_W'(4))
      else $error("channel counter out of range");

   a_seen_bound: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= MAX_LENGTH_DIGITS)
      else $error("length digit counter out of range");
`endif

endmodule

// ===== sim/dlbd_checker.sv =====
// Checker for the block deframer: follows the parse of each accepted byte and compares result beats.
module dlbd_checker import dlbd_pkg::*; (
   input  logic clock,
   input  logic reset,
   dlbd_req_if  req_chan,
   dlbd_rsp_if  rsp_chan,
   dlbd_csr_if  csr_chan,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [POINTS_W-1:0]  points_reg;
   logic [MASK_W-1:0]    mask_reg;
   phase_type            parse_state;
   logic [DCOUNT_W-1:0]  digits_wanted;
   logic [DCOUNT_W-1:0]  digits_taken;
   logic [LENGTH_W-1:0]  length_sum;
   logic                 length_done;
   logic [CHCOUNT_W-1:0] chan_index;
   logic [POINTS_W-1:0]  sample_index;
   logic [OFFSET_W:0]    buffer_offset;
   logic [EVENT_W-1:0]   event_count;
   rsp_beat_type         expected_beats[$];

   function automatic rsp_beat_type make_beat(input logic [KIND_W-1:0] kind,
                                              input logic [BYTE_W-1:0] sample,
                                              input logic [CHAN_W-1:0] chan,
                                              input logic [OFFSET_W-1:0] offset,
                                              input logic [LENGTH_W-1:0] length);
      rsp_beat_type beat;
      beat.result_kind     = kind;
      beat.sample_value    = sample;
      beat.channel_number  = chan;
      beat.event_offset    = offset;
      beat.declared_length = length;
      beat.event_number    = event_count;
      return beat;
   endfunction

   task automatic open_header();
      parse_state   = PH_HEADER;
      digits_wanted = COUNT_PENDING;
      digits_taken  = '0;
      length_sum    = '0;
      length_done   = 1'b0;
   endtask

   task automatic close_header();
      expected_beats.push_back(make_beat(KIND_HEADER, '0, chan_index[CHAN_W-1:0],
                                         buffer_offset[OFFSET_W-1:0], length_sum));
      parse_state  = PH_SAMPLES;
      sample_index = '0;
   endtask

   task automatic advance_parser(input logic [BYTE_W-1:0] b);
      logic        is_digit;
      int unsigned digit;
      int unsigned points;
      int unsigned chans;
      is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      digit    = is_digit ? int'(b - CHAR_ZERO) : 0;
      points   = (points_reg == 0) ? 1 : ((points_reg > MAX_POINTS) ? MAX_POINTS : points_reg);
      chans    = $countones(mask_reg);
      if (chans == 0) chans = 1;
      case (parse_state)
         PH_AWAIT: begin
            if (b == CHAR_HASH) open_header();
         end
         PH_HEADER: begin
            if (b == CHAR_HASH) begin
               open_header();
            end else if (digits_wanted == COUNT_PENDING) begin
               digits_wanted = (digit > MAX_LENGTH_DIGITS) ? MAX_LENGTH_DIGITS
                                                           : DCOUNT_W'(digit);
               digits_taken  = '0;
               if (digits_wanted == 0) close_header();
            end else begin
               if (is_digit && !length_done) begin
                  length_sum = LENGTH_W'(length_sum * 10 + digit);
               end else begin
                  length_done = 1'b1;
               end
               digits_taken = digits_taken + 1'b1;
               if (digits_taken >= digits_wanted) close_header();
            end
         end
         PH_SAMPLES: begin
            expected_beats.push_back(make_beat(KIND_SAMPLE, b, chan_index[CHAN_W-1:0],
                                               buffer_offset[OFFSET_W-1:0], '0));
            buffer_offset = buffer_offset + 1'b1;
            sample_index  = sample_index + 1'b1;
            if (sample_index >= points) begin
               sample_index = '0;
               chan_index   = chan_index + 1'b1;
               parse_state  = (chan_index >= chans) ? PH_TRAILER : PH_AWAIT;
            end
         end
         default: begin
            if (b == CHAR_NEWLINE) begin
               expected_beats.push_back(make_beat(KIND_EVENT, '0, '0, '0, '0));
               event_count   = event_count + 1'b1;
               chan_index    = '0;
               buffer_offset = '0;
               sample_index  = '0;
               parse_state   = PH_AWAIT;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [EVENT_W-1:0] want,
                              input logic [EVENT_W-1:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_beat_type want;
      if (reset) begin
         points_reg    = POINTS_RESET;
         mask_reg      = MASK_RESET;
         parse_state   = PH_AWAIT;
         digits_wanted = '0;
         digits_taken  = '0;
         length_sum    = '0;
         length_done   = 1'b0;
         chan_index    = '0;
         sample_index  = '0;
         buffer_offset = '0;
         event_count   = '0;
         fail_count    = 0;
         expected_beats.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) advance_parser(req_chan.stream_byte);
         if (csr_chan.valid && csr_chan.ready) begin
            if (csr_chan.index == CSR_POINTS) begin
               points_reg = csr_chan.data[POINTS_W-1:0];
            end else if (csr_chan.index == CSR_MASK) begin
               mask_reg = csr_chan.data[MASK_W-1:0];
            end
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_beats.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with none expected, expected nothing, actual kind %0d",
                        $time, rsp_chan.result_kind);
            end else begin
               want = expected_beats.pop_front();
               check_field("result_kind", EVENT_W'(want.result_kind),
                           EVENT_W'(rsp_chan.result_kind));
               check_field("sample_value", EVENT_W'(want.sample_value),
                           EVENT_W'(rsp_chan.sample_value));
               check_field("channel_number", EVENT_W'(want.channel_number),
                           EVENT_W'(rsp_chan.channel_number));
               check_field("event_offset", EVENT_W'(want.event_offset),
                           EVENT_W'(rsp_chan.event_offset));
               check_field("declared_length", EVENT_W'(want.declared_length),
                           EVENT_W'(rsp_chan.declared_length));
               check_field("event_number", want.event_number, rsp_chan.event_number);
            end
         end
      end
      pending = expected_beats.size();
   end

endmodule

// ===== sim/testbench.sv =====
// Top of the block deframer test: clock, reset, byte and register stimulus, and the verdict.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import dlbd_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          fail_count;
   int          pending;
   int unsigned send_idle = 27;
   int unsigned recv_idle = 51;
   int unsigned items_sent = 0;
   int unsigned cur_points = POINTS_RESET;
   int unsigned cur_chans = 1;

   dlbd_req_if req_chan ();
   dlbd_rsp_if rsp_chan ();
   dlbd_csr_if csr_chan ();

   definite_length_block_deframer u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   dlbd_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_idle);
   end

   initial begin
      #3_000_000;
      $display("definite_length_block_deframer test failed");
      $finish;
   end

   function automatic logic [BYTE_W-1:0] noise_byte(input logic [BYTE_W-1:0] excluded,
                                                    input bit no_digit);
      logic [BYTE_W-1:0] b;
      do begin
         b = BYTE_W'($urandom_range(255));
      end while (b == excluded || (no_digit && b >= CHAR_ZERO && b <= CHAR_NINE));
      return b;
   endfunction

   task automatic put_byte(input logic [BYTE_W-1:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.stream_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= index;
      csr_chan.data  <= data;
      do @(posedge clock); while (!csr_chan.ready);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
      if (index == CSR_POINTS) begin
         cur_points = (data == 0) ? 1 : ((data > MAX_POINTS) ? MAX_POINTS : data);
      end else begin
         cur_chans = $countones(data[MASK_W-1:0]);
         if (cur_chans == 0) cur_chans = 1;
      end
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] points,
                             input logic [MASK_W-1:0] mask);
      settle();
      write_reg(CSR_POINTS, points);
      write_reg(CSR_MASK, CSR_DATA_W'(mask));
   endtask

   task automatic send_event(input int unsigned nch, input int unsigned npts);
      int unsigned ndig;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 3)) put_byte(noise_byte(CHAR_HASH, 1'b0));
      end
      for (int c = 0; c < nch; c++) begin
         put_byte(CHAR_HASH);
         if ($urandom_range(9) == 0) begin
            put_byte(CHAR_ZERO + BYTE_W'($urandom_range(2, 9)));
            put_byte(noise_byte(CHAR_HASH, 1'b0));
            put_byte(CHAR_HASH);
         end
         if ($urandom_range(4) == 0) begin
            put_byte(noise_byte(CHAR_HASH, 1'b1));
            ndig = 0;
         end else begin
            ndig = $urandom_range(9);
            put_byte(CHAR_ZERO + BYTE_W'(ndig));
         end
         repeat (ndig) begin
            put_byte(($urandom_range(9) == 0) ? noise_byte(CHAR_HASH, 1'b0)
                                              : CHAR_ZERO + BYTE_W'($urandom_range(9)));
         end
         repeat (npts) put_byte(BYTE_W'($urandom_range(255)));
         if ($urandom_range(39) == 0) return;
      end
      repeat ($urandom_range(3)) begin
         put_byte($urandom_range(1) ? CHAR_SEMI : noise_byte(CHAR_NEWLINE, 1'b0));
      end
      put_byte(CHAR_NEWLINE);
   endtask

   initial begin
      logic [BYTE_W-1:0] script[$];
      int unsigned       phase_end;
      req_chan.valid       = 1'b0;
      req_chan.stream_byte = '0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_POINTS;
      csr_chan.data        = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      set_config(CSR_DATA_W'(1), 4'b0000);
      script = '{8'h00, CHAR_HASH, "3", CHAR_HASH, "0", 8'hFF, CHAR_SEMI, CHAR_NEWLINE,
                 CHAR_HASH, "9", "9", "9", "9", "9", "9", "9", "9", "9", "9", 8'h00,
                 CHAR_NEWLINE,
                 CHAR_HASH, "3", "1", "x", "2", CHAR_NEWLINE, 8'h80, CHAR_NEWLINE,
                 CHAR_HASH, "A", 8'h55, CHAR_NEWLINE};
      foreach (script[i]) put_byte(script[i]);

      set_config(21'h1FFFFF, 4'hF);
      script = '{CHAR_HASH, "1", "7", CHAR_HASH, CHAR_NEWLINE, 8'hC3};
      foreach (script[i]) put_byte(script[i]);
      settle();
      write_reg(CSR_POINTS, MAX_POINTS);
      put_byte(8'h3C);
      put_byte(8'hA5);
      settle();
      write_reg(CSR_POINTS, CSR_DATA_W'(2));
      write_reg(CSR_MASK, CSR_DATA_W'(4'b0010));
      put_byte(8'h5A);
      put_byte(CHAR_NEWLINE);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 27 : ((ph == 1) ? 51 : 0);
         recv_idle = (ph == 0) ? 51 : ((ph == 1) ? 27 : 0);
         phase_end = items_sent + 470;
         while (items_sent < phase_end) begin
            if ($urandom_range(7) == 0) begin
               set_config(CSR_DATA_W'(($urandom_range(15) == 0) ? 40 : $urandom_range(0, 6)),
                          MASK_W'($urandom_range(15)));
            end
            send_event(cur_chans, cur_points);
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("definite_length_block_deframer test passed");
      end else begin
         $display("definite_length_block_deframer test failed");
      end
      $finish;
   end

endmodule
